### rtl/core/assert_macros.svh
// Assertion helpers shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every sampled edge outside reset.
`define DCP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Condition must never be seen outside reset.
`define DCP_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define DCP_ASSERT(lbl, clk, rstn, prop, msg)
`define DCP_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

### rtl/core/dcp_pkg.sv
package dcp_pkg;

  // Register stages in the front end, from accept to queue push.
  localparam int FRONT_LAT = 3;
  // One root bit per square-root stage, one quotient bit per divide stage.
  localparam int SQ_STEPS = 32;
  localparam int DV_STEPS = 33;

  typedef struct packed {
    logic [2:0]        sgn;
    logic [2:0][31:0]  mag;
    logic [63:0]       sq;
    logic [30:0]       rest;
    logic              pa;
    logic              pb;
    logic              act;
  } front_item_t;

  typedef struct packed {
    logic empty;
    logic near_full;
  } fifo_stat_t;

endpackage

### rtl/core/distance_constraint_projection.sv
// Distance constraint projection, one constraint per transaction. Raise start
// with the two positions, pinned flags, rest length and enable; it is taken on
// any edge where busy is low, so a new constraint can enter every cycle. The
// result appears on the out_ ports for exactly one cycle, marked by
// out_valid, and there is no way to stall it: capture it then or lose it.
// The path runs through a 32-stage pipelined square root (one root
// bit per stage) and a 33-stage pipelined divider (one quotient bit per stage)
// behind a three-stage front end and a small queue. busy only rises if the
// queue backs up, which the never-stalling back end does not let happen in
// normal flow. Values are signed fixed point; the result does not depend on
// the fraction width, since every step is a ratio of like-scaled values.
module distance_constraint_projection #(
  parameter int FIFO_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_pos_a_x,
  input  logic [31:0] in_pos_a_y,
  input  logic [31:0] in_pos_a_z,
  input  logic [31:0] in_pos_b_x,
  input  logic [31:0] in_pos_b_y,
  input  logic [31:0] in_pos_b_z,
  input  logic        in_pinned_a,
  input  logic        in_pinned_b,
  input  logic [30:0] in_rest_length,
  input  logic        in_active,
  output logic        out_valid,
  output logic [31:0] out_move_a_x,
  output logic [31:0] out_move_a_y,
  output logic [31:0] out_move_a_z,
  output logic [31:0] out_move_b_x,
  output logic [31:0] out_move_b_y,
  output logic [31:0] out_move_b_z,
  output logic        out_degenerate
);

  logic                 take;
  logic                 push;
  dcp_pkg::front_item_t f_item, q_item;
  dcp_pkg::fifo_stat_t  q_stat;
  logic                 pop;
  logic [2:0][31:0]     move_a, move_b;

  // Accept a transaction whenever the queue has room for it.
  assign take = start && !busy;
  assign busy = q_stat.near_full;

  dcp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .pos_a       ({in_pos_a_z, in_pos_a_y, in_pos_a_x}),
    .pos_b       ({in_pos_b_z, in_pos_b_y, in_pos_b_x}),
    .pinned_a    (in_pinned_a),
    .pinned_b    (in_pinned_b),
    .rest_length (in_rest_length),
    .active      (in_active),
    .push        (push),
    .item        (f_item)
  );

  // Drain the queue every cycle: the back end never holds off.
  assign pop = !q_stat.empty;

  dcp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .item_in  (f_item),
    .pop      (pop),
    .item_out (q_item),
    .stat     (q_stat)
  );

  dcp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (pop),
    .item       (q_item),
    .out_valid  (out_valid),
    .move_a     (move_a),
    .move_b     (move_b),
    .degenerate (out_degenerate)
  );

  assign out_move_a_x = move_a[0];
  assign out_move_a_y = move_a[1];
  assign out_move_a_z = move_a[2];
  assign out_move_b_x = move_b[0];
  assign out_move_b_y = move_b[1];
  assign out_move_b_z = move_b[2];

endmodule

### rtl/core/dcp_front.sv
module dcp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  logic [2:0][31:0]     pos_a,
  input  logic [2:0][31:0]     pos_b,
  input  logic                 pinned_a,
  input  logic                 pinned_b,
  input  logic [30:0]          rest_length,
  input  logic                 active,
  output logic                 push,
  output dcp_pkg::front_item_t item
);

  logic [2:0]       sgn_nxt;
  logic [2:0][31:0] mag_nxt;

  logic             f1_vld_r, f2_vld_r, f3_vld_r;
  logic [2:0]       f1_sgn_r, f2_sgn_r;
  logic [2:0][31:0] f1_mag_r, f2_mag_r;
  logic [2:0][63:0] f2_sqr_r;
  logic [30:0]      f1_rest_r, f2_rest_r;
  logic [2:0]       f1_flg_r, f2_flg_r;
  dcp_pkg::front_item_t f3_item_r;

  // Offset B - A, clamped to 32 bits, split into sign and magnitude.
  always_comb begin
    logic [32:0] dif;
    logic [31:0] sat;
    for (int i = 0; i < 3; i++) begin
      dif = {pos_b[i][31], pos_b[i]} - {pos_a[i][31], pos_a[i]};
      if (dif[32] != dif[31]) begin
        sat = dif[32] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
        sat = dif[31:0];
      end
      sgn_nxt[i] = sat[31];
      mag_nxt[i] = sat[31] ? (~sat + 32'd1) : sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
      f3_vld_r <= 1'b0;
    end else begin
      f1_vld_r <= take;
      f2_vld_r <= f1_vld_r;
      f3_vld_r <= f2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    f1_sgn_r  <= sgn_nxt;
    f1_mag_r  <= mag_nxt;
    f1_rest_r <= rest_length;
    f1_flg_r  <= {pinned_a, pinned_b, active};
    for (int i = 0; i < 3; i++) begin
      f2_sqr_r[i] <= {32'd0, f1_mag_r[i]} * {32'd0, f1_mag_r[i]};
    end
    f2_sgn_r  <= f1_sgn_r;
    f2_mag_r  <= f1_mag_r;
    f2_rest_r <= f1_rest_r;
    f2_flg_r  <= f1_flg_r;
    f3_item_r.sgn  <= f2_sgn_r;
    f3_item_r.mag  <= f2_mag_r;
    // Each square is at most 2^62, so the sum fits 64 bits.
    f3_item_r.sq   <= f2_sqr_r[0] + f2_sqr_r[1] + f2_sqr_r[2];
    f3_item_r.rest <= f2_rest_r;
    f3_item_r.pa   <= f2_flg_r[2];
    f3_item_r.pb   <= f2_flg_r[1];
    f3_item_r.act  <= f2_flg_r[0];
  end

  assign push = f3_vld_r;
  assign item = f3_item_r;

endmodule

### rtl/core/dcp_fifo.sv
`include "assert_macros.svh"

module dcp_fifo #(
  parameter int DEPTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  dcp_pkg::front_item_t item_in,
  input  logic                 pop,
  output dcp_pkg::front_item_t item_out,
  output dcp_pkg::fifo_stat_t  stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dcp_pkg::front_item_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

  assign item_out       = mem_r[rd_ptr_r];
  assign stat.empty     = (count_r == '0);
  // Leave room for every transaction still in the front stages.
  assign stat.near_full = (count_r >= CNT_W'(DEPTH - dcp_pkg::FRONT_LAT));

  `DCP_NEVER(a_no_overflow, clk, rst_n, push && !pop && (count_r == CNT_W'(DEPTH)), "queue overflow")
  `DCP_ASSERT(a_count_up, clk, rst_n, push && !pop |=> count_r == $past(count_r) + CNT_W'(1), "count did not advance")

endmodule

### rtl/core/dcp_back.sv
`include "assert_macros.svh"

module dcp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  dcp_pkg::front_item_t item,
  output logic                 out_valid,
  output logic [2:0][31:0]     move_a,
  output logic [2:0][31:0]     move_b,
  output logic                 degenerate
);

  localparam int SQ = dcp_pkg::SQ_STEPS;
  localparam int DV = dcp_pkg::DV_STEPS;

  function automatic logic [31:0] sat_mag(input logic neg, input logic [32:0] mag);
    logic [31:0] res;
    if (neg) begin
      res = (mag >= 33'h0_8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
    end else begin
      res = (mag > 33'h0_7fff_ffff) ? 32'h7fff_ffff : mag[31:0];
    end
    return res;
  endfunction

  // Square-root pipeline.
  logic [SQ:0]      sq_vld_r;
  logic [63:0]      sq_rad_r  [SQ+1];
  logic [33:0]      sq_rem_r  [SQ+1];
  logic [31:0]      sq_root_r [SQ+1];
  logic [2:0][31:0] sq_mag_r  [SQ+1];
  logic [2:0]       sq_sgn_r  [SQ+1];
  logic [33:0]      sq_flg_r  [SQ+1];
  logic [63:0]      sq_rad_nxt  [SQ];
  logic [33:0]      sq_rem_nxt  [SQ];
  logic [31:0]      sq_root_nxt [SQ];

  always_comb begin
    logic [33:0] rem2;
    logic [33:0] trial;
    for (int k = 0; k < SQ; k++) begin
      rem2  = {sq_rem_r[k][31:0], sq_rad_r[k][63:62]};
      trial = {sq_root_r[k], 2'b01};
      sq_rad_nxt[k] = {sq_rad_r[k][61:0], 2'b00};
      if (rem2 >= trial) begin
        sq_rem_nxt[k]  = rem2 - trial;
        sq_root_nxt[k] = {sq_root_r[k][30:0], 1'b1};
      end else begin
        sq_rem_nxt[k]  = rem2;
        sq_root_nxt[k] = {sq_root_r[k][30:0], 1'b0};
      end
    end
  end

  // Length stage: rest difference, divisor and rounding half.
  logic             p1_vld_r, p2_vld_r;
  logic [2:0][31:0] p1_mag_r;
  logic [2:0]       p1_sgn_r, p2_sgn_r;
  logic [31:0]      p1_dmag_r, p1_half_r, p2_half_r;
  logic [32:0]      p1_den_r, p2_den_r;
  logic [4:0]       p1_flg_r, p2_flg_r;   // dneg, kill, degen, pa, pb
  logic [2:0][63:0] p2_prod_r;

  logic [30:0] f_rest;
  logic        f_pa, f_pb, f_act;
  logic [31:0] len;
  logic [32:0] diff;
  logic        len_zero;

  assign f_rest   = sq_flg_r[SQ][33:3];
  assign f_pa     = sq_flg_r[SQ][2];
  assign f_pb     = sq_flg_r[SQ][1];
  assign f_act    = sq_flg_r[SQ][0];
  assign len      = sq_root_r[SQ];
  assign diff     = {1'b0, len} - {2'b00, f_rest};
  assign len_zero = (len == 32'd0);

  // Divide pipeline, three lanes sharing one divisor.
  logic [DV:0]      dv_vld_r;
  logic [2:0][63:0] dv_num_r [DV+1];
  logic [2:0][33:0] dv_rem_r [DV+1];
  logic [2:0][32:0] dv_q_r   [DV+1];
  logic [32:0]      dv_den_r [DV+1];
  logic [2:0]       dv_sgn_r [DV+1];
  logic [4:0]       dv_flg_r [DV+1];
  logic [2:0][63:0] dv_num_nxt [DV];
  logic [2:0][33:0] dv_rem_nxt [DV];
  logic [2:0][32:0] dv_q_nxt   [DV];
  logic [2:0][63:0] num0;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num0[i] = p2_prod_r[i] + {32'd0, p2_half_r};
    end
  end

  always_comb begin
    logic [33:0] rem2;
    for (int k = 0; k < DV; k++) begin
      for (int i = 0; i < 3; i++) begin
        rem2 = {dv_rem_r[k][i][32:0], dv_num_r[k][i][32]};
        dv_num_nxt[k][i] = {dv_num_r[k][i][62:0], 1'b0};
        if (rem2 >= {1'b0, dv_den_r[k]}) begin
          dv_rem_nxt[k][i] = rem2 - {1'b0, dv_den_r[k]};
          dv_q_nxt[k][i]   = {dv_q_r[k][i][31:0], 1'b1};
        end else begin
          dv_rem_nxt[k][i] = rem2;
          dv_q_nxt[k][i]   = {dv_q_r[k][i][31:0], 1'b0};
        end
      end
    end
  end

  // Output stage.
  logic             out_vld_r, out_degen_r;
  logic [2:0][31:0] out_a_r, out_b_r;
  logic [2:0][31:0] a_nxt, b_nxt;

  always_comb begin
    logic [32:0] q;
    logic        qz, neg;
    for (int i = 0; i < 3; i++) begin
      q   = dv_q_r[DV][i];
      qz  = (q == 33'd0);
      neg = (dv_sgn_r[DV][i] ^ dv_flg_r[DV][4]) & !qz;
      a_nxt[i] = '0;
      b_nxt[i] = '0;
      if (!dv_flg_r[DV][3]) begin
        if (!dv_flg_r[DV][1]) begin
          a_nxt[i] = sat_mag(neg, q);
        end
        if (!dv_flg_r[DV][0]) begin
          b_nxt[i] = sat_mag(!neg && !qz, q);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r  <= '0;
      p1_vld_r  <= 1'b0;
      p2_vld_r  <= 1'b0;
      dv_vld_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      sq_vld_r  <= {sq_vld_r[SQ-1:0], take};
      p1_vld_r  <= sq_vld_r[SQ];
      p2_vld_r  <= p1_vld_r;
      dv_vld_r  <= {dv_vld_r[DV-1:0], p2_vld_r};
      out_vld_r <= dv_vld_r[DV];
    end
  end

  always_ff @(posedge clk) begin
    sq_rad_r[0]  <= item.sq;
    sq_rem_r[0]  <= '0;
    sq_root_r[0] <= '0;
    sq_mag_r[0]  <= item.mag;
    sq_sgn_r[0]  <= item.sgn;
    sq_flg_r[0]  <= {item.rest, item.pa, item.pb, item.act};
    for (int k = 0; k < SQ; k++) begin
      sq_rad_r[k+1]  <= sq_rad_nxt[k];
      sq_rem_r[k+1]  <= sq_rem_nxt[k];
      sq_root_r[k+1] <= sq_root_nxt[k];
      sq_mag_r[k+1]  <= sq_mag_r[k];
      sq_sgn_r[k+1]  <= sq_sgn_r[k];
      sq_flg_r[k+1]  <= sq_flg_r[k];
    end

    p1_mag_r  <= sq_mag_r[SQ];
    p1_sgn_r  <= sq_sgn_r[SQ];
    p1_dmag_r <= diff[32] ? (~diff[31:0] + 32'd1) : diff[31:0];
    // Both free: halve the correction by doubling the divisor.
    p1_den_r  <= (!f_pa && !f_pb) ? {len, 1'b0} : {1'b0, len};
    p1_half_r <= (!f_pa && !f_pb) ? len : {1'b0, len[31:1]};
    p1_flg_r  <= {diff[32], !f_act || len_zero || (f_pa && f_pb), f_act && len_zero,
                  f_pa, f_pb};

    for (int i = 0; i < 3; i++) begin
      p2_prod_r[i] <= {32'd0, p1_mag_r[i]} * {32'd0, p1_dmag_r};
    end
    p2_sgn_r  <= p1_sgn_r;
    p2_half_r <= p1_half_r;
    p2_den_r  <= p1_den_r;
    p2_flg_r  <= p1_flg_r;

    // Quotient stays below 2^33, so the top numerator bits start below the divisor.
    dv_num_r[0] <= num0;
    for (int i = 0; i < 3; i++) begin
      dv_rem_r[0][i] <= {3'b000, num0[i][63:33]};
    end
    dv_q_r[0]   <= '0;
    dv_den_r[0] <= p2_den_r;
    dv_sgn_r[0] <= p2_sgn_r;
    dv_flg_r[0] <= p2_flg_r;
    for (int k = 0; k < DV; k++) begin
      dv_num_r[k+1] <= dv_num_nxt[k];
      dv_rem_r[k+1] <= dv_rem_nxt[k];
      dv_q_r[k+1]   <= dv_q_nxt[k];
      dv_den_r[k+1] <= dv_den_r[k];
      dv_sgn_r[k+1] <= dv_sgn_r[k];
      dv_flg_r[k+1] <= dv_flg_r[k];
    end

    out_a_r     <= a_nxt;
    out_b_r     <= b_nxt;
    out_degen_r <= dv_flg_r[DV][2];
  end

  assign out_valid  = out_vld_r;
  assign move_a     = out_a_r;
  assign move_b     = out_b_r;
  assign degenerate = out_degen_r;

  `DCP_ASSERT(a_degen_zero, clk, rst_n, out_vld_r && out_degen_r |-> (out_a_r == '0) && (out_b_r == '0), "degenerate result moved")

endmodule
